// ===== src/accumulator_machine_executor_defines.svh =====
`ifndef ACCUMULATOR_MACHINE_EXECUTOR_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTOR_DEFINES_SVH

// checked only out of reset
`define AME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AME_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ame_pkg.sv =====
`timescale 1ns / 1ps

package ame_pkg;

    localparam int OP_W     = 4;
    localparam int IDX_W    = 4;
    localparam int IMM_W    = 32;
    localparam int ACC_W    = 32;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_ADD   = 4'd0;
    localparam opcode_t OP_SUB   = 4'd1;
    localparam opcode_t OP_MUL   = 4'd2;
    localparam opcode_t OP_DIV   = 4'd3;
    localparam opcode_t OP_MOD   = 4'd4;
    localparam opcode_t OP_LOAD  = 4'd5;
    localparam opcode_t OP_STORE = 4'd6;
    localparam opcode_t OP_IN    = 4'd7;
    localparam opcode_t OP_OUT   = 4'd8;
    localparam opcode_t OP_CLEAR = 4'd9;
    localparam opcode_t OP_END   = 4'd10;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_DIV_ZERO = 2'd1;
    localparam status_t ST_HALTED   = 2'd2;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

// ===== src/ame_alu.sv =====
`timescale 1ns / 1ps

module ame_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ame_pkg::alu_req_t     req,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);
    import ame_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        A_IDLE,
        A_SUM,
        A_NEG_A,
        A_NEG_B,
        A_RUN,
        A_FIX
    } alu_state_t;

    alu_state_t            state_reg;
    alu_op_t               op_reg;
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH-1:0] z_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  sa_reg;
    logic                  sb_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] result_reg;

    // the one shared adder, DATA_WIDTH+1 bits so the top bit is the borrow
    logic [DATA_WIDTH:0] add_a;
    logic [DATA_WIDTH:0] add_b;
    logic [DATA_WIDTH:0] add_sum;
    logic                add_sub;
    logic                neg_result;

    assign neg_result = (op_reg == ALU_DIV) ? (sa_reg ^ sb_reg) : sa_reg;

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
            end
            A_SUM:
            begin
                add_a   = {1'b0, x_reg};
                add_b   = {1'b0, y_reg};
                add_sub = (op_reg == ALU_SUB);
            end
            A_NEG_A:
            begin
                add_b   = {1'b0, z_reg};
                add_sub = 1'b1;
            end
            A_NEG_B:
            begin
                add_b   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            A_RUN:
            begin
                if (op_reg == ALU_MUL)
                begin
                    add_a = {1'b0, x_reg};
                    add_b = z_reg[0] ? {1'b0, y_reg} : '0;
                end
                else
                begin
                    // partial remainder shifted left by one, next dividend bit in
                    add_a   = {1'b0, x_reg[DATA_WIDTH-2:0], z_reg[DATA_WIDTH-1]};
                    add_b   = {1'b0, y_reg};
                    add_sub = 1'b1;
                end
            end
            A_FIX:
            begin
                add_b   = {1'b0, (op_reg == ALU_DIV) ? z_reg : x_reg};
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + {{DATA_WIDTH{1'b0}}, add_sub};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg <= req.op;
                        sa_reg <= a[DATA_WIDTH-1];
                        sb_reg <= b[DATA_WIDTH-1];
                        unique case (req.op)
                            ALU_ADD, ALU_SUB:
                            begin
                                x_reg     <= a;
                                y_reg     <= b;
                                state_reg <= A_SUM;
                            end
                            ALU_MUL:
                            begin
                                x_reg     <= '0;
                                y_reg     <= a;
                                z_reg     <= b;
                                cnt_reg   <= CNT_W'(DATA_WIDTH - 1);
                                state_reg <= A_RUN;
                            end
                            ALU_DIV, ALU_MOD:
                            begin
                                x_reg     <= '0;
                                y_reg     <= b;
                                z_reg     <= a;
                                state_reg <= A_NEG_A;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                A_SUM:
                begin
                    result_reg <= add_sum[DATA_WIDTH-1:0];
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                A_NEG_A:
                begin
                    if (sa_reg)
                    begin
                        z_reg <= add_sum[DATA_WIDTH-1:0];
                    end
                    state_reg <= A_NEG_B;
                end
                A_NEG_B:
                begin
                    if (sb_reg)
                    begin
                        y_reg <= add_sum[DATA_WIDTH-1:0];
                    end
                    cnt_reg   <= CNT_W'(DATA_WIDTH - 1);
                    state_reg <= A_RUN;
                end
                A_RUN:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (op_reg == ALU_MUL)
                    begin
                        x_reg <= add_sum[DATA_WIDTH-1:0];
                        y_reg <= {y_reg[DATA_WIDTH-2:0], 1'b0};
                        z_reg <= {1'b0, z_reg[DATA_WIDTH-1:1]};
                    end
                    else if (!add_sum[DATA_WIDTH])
                    begin
                        x_reg <= add_sum[DATA_WIDTH-1:0];
                        z_reg <= {z_reg[DATA_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        x_reg <= {x_reg[DATA_WIDTH-2:0], z_reg[DATA_WIDTH-1]};
                        z_reg <= {z_reg[DATA_WIDTH-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        if (op_reg == ALU_MUL)
                        begin
                            result_reg <= add_sum[DATA_WIDTH-1:0];
                            done_reg   <= 1'b1;
                            state_reg  <= A_IDLE;
                        end
                        else
                        begin
                            state_reg <= A_FIX;
                        end
                    end
                end
                A_FIX:
                begin
                    // restore signs: quotient by sign mismatch, remainder by dividend
                    if (neg_result)
                    begin
                        result_reg <= add_sum[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        result_reg <= (op_reg == ALU_DIV) ? z_reg : x_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/accumulator_machine_executor.sv =====
`timescale 1ns / 1ps
// load, store, in, out, clear, end, unused codes, halted items and a zero divisor pass from
// S_EXEC straight to S_FINISH; add, sub, mul, div and mod wait in S_WAIT for the shared adder,
// which steps mul and div one quotient or product bit per cycle
// a new item is taken only once the last has left S_FINISH; a result may wait at the output
// while the next item runs
// reset clears the accumulator, all memory registers, the halted flag and the output beat

module accumulator_machine_executor #(
    parameter int NUM_REGS   = 10,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ame_pkg::OP_W-1:0]       op,
    input  logic                           operand_is_register,
    input  logic [ame_pkg::IDX_W-1:0]      register_index,
    input  logic signed [ame_pkg::IMM_W-1:0] immediate_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ame_pkg::ACC_W-1:0] accumulator,
    output logic                           emit,
    output logic [ame_pkg::STATUS_W-1:0]   status,
    output logic                           halted
);
    import ame_pkg::*;

    localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t                state_reg;
    opcode_t               op_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic                  store_en_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] mem_reg [NUM_REGS];
    logic                  halted_reg;
    logic                  emit_pend_reg;
    status_t               status_pend_reg;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_acc_reg;
    logic                  out_emit_reg;
    status_t               out_status_reg;
    logic                  out_halted_reg;

    logic                  in_beat;
    logic                  idx_in_range;
    logic [DATA_WIDTH-1:0] imm_ext;
    logic [DATA_WIDTH-1:0] operand;
    alu_req_t              alu_req;
    logic                  alu_done;
    logic [DATA_WIDTH-1:0] alu_result;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_beat      = in_valid && in_ready;
    assign idx_in_range = ({1'b0, register_index} < (IDX_W + 1)'(NUM_REGS));
    assign imm_ext      = DATA_WIDTH'(immediate_value);

    // in takes the immediate whatever the operand flag says
    always_comb
    begin
        if ((op == OP_IN) || !operand_is_register)
        begin
            operand = imm_ext;
        end
        else if (idx_in_range)
        begin
            operand = mem_reg[register_index[IDX_BITS-1:0]];
        end
        else
        begin
            operand = '0;
        end
    end

    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        if ((state_reg == S_EXEC) && !halted_reg)
        begin
            unique case (op_reg)
                OP_ADD:
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_ADD;
                end
                OP_SUB:
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_SUB;
                end
                OP_MUL:
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                end
                OP_DIV:
                begin
                    alu_req.start = (b_reg != '0);
                    alu_req.op    = ALU_DIV;
                end
                OP_MOD:
                begin
                    alu_req.start = (b_reg != '0);
                    alu_req.op    = ALU_MOD;
                end
                default:
                begin
                end
            endcase
        end
    end

    ame_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (acc_reg),
        .b     (b_reg),
        .done  (alu_done),
        .result(alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else
        begin
            // S_FINISH reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        op_reg          <= op;
                        b_reg           <= operand;
                        store_en_reg    <= operand_is_register && idx_in_range;
                        idx_reg         <= register_index[IDX_BITS-1:0];
                        emit_pend_reg   <= 1'b0;
                        status_pend_reg <= ST_OK;
                        state_reg       <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (halted_reg)
                    begin
                        status_pend_reg <= ST_HALTED;
                        state_reg       <= S_FINISH;
                    end
                    else if (alu_req.start)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_DIV, OP_MOD:
                            begin
                                status_pend_reg <= ST_DIV_ZERO;
                            end
                            OP_LOAD, OP_IN:
                            begin
                                acc_reg <= b_reg;
                            end
                            OP_STORE:
                            begin
                                if (store_en_reg)
                                begin
                                    mem_reg[idx_reg] <= acc_reg;
                                end
                            end
                            OP_OUT:
                            begin
                                emit_pend_reg <= 1'b1;
                            end
                            OP_CLEAR:
                            begin
                                acc_reg <= '0;
                                for (int i = 0; i < NUM_REGS; i++)
                                begin
                                    mem_reg[i] <= '0;
                                end
                            end
                            OP_END:
                            begin
                                halted_reg <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                        state_reg <= S_FINISH;
                    end
                end
                S_WAIT:
                begin
                    if (alu_done)
                    begin
                        acc_reg   <= alu_result;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // hold until the previous beat has left the output register
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_acc_reg    <= acc_reg;
                        out_emit_reg   <= emit_pend_reg;
                        out_status_reg <= status_pend_reg;
                        out_halted_reg <= halted_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign accumulator = ACC_W'(out_acc_reg);
    assign emit        = out_emit_reg;
    assign status      = out_status_reg;
    assign halted      = out_halted_reg;

endmodule

// ===== src/ame_checker.sv =====
`timescale 1ns / 1ps
`include "accumulator_machine_executor_defines.svh"

module ame_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [ame_pkg::ACC_W-1:0] accumulator,
    input logic                         emit,
    input logic [ame_pkg::STATUS_W-1:0] status,
    input logic                         halted
);
    import ame_pkg::*;

    `AME_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_n |=> !out_valid, "result beat shown after reset")
    `AME_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(accumulator), "stalled result beat dropped or changed")
    `AME_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "input taken while an item is at work")
    `AME_ASSERT(a_halt_sticky, halted |=> halted, "halted flag cleared without reset")
    `AME_ASSERT(a_status_flags, out_valid |-> (status != ST_HALTED || halted) && (!emit || status == ST_OK), "status, emit and halted disagree")

endmodule

bind accumulator_machine_executor ame_checker u_ame_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accumulator(accumulator),
    .emit       (emit),
    .status     (status),
    .halted     (halted)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import ame_pkg::*;

localparam int MEM_DEPTH = 10;

typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             emit;
    status_t          status;
    logic             halted;
} exec_result_t;

// tracks the accumulator, memory and halt flag, and holds the results still owed
class acc_machine_tracker;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] mem [MEM_DEPTH];
    bit               stopped;
    exec_result_t     owed_results[$];
    int               mismatches;

    function new();
        acc = '0;
        foreach (mem[i]) mem[i] = '0;
        stopped = 1'b0;
        mismatches = 0;
    endfunction

    function int pending_count();
        return owed_results.size();
    endfunction

    function void execute_instr(input opcode_t o, input logic use_reg,
                                input logic [IDX_W-1:0] idx, input logic [IMM_W-1:0] imm);
        exec_result_t res;
        logic [ACC_W-1:0] b;
        logic [ACC_W-1:0] mag_a;
        logic [ACC_W-1:0] mag_b;
        logic [ACC_W-1:0] quo;
        logic [ACC_W-1:0] rem;
        res.emit = 1'b0;
        res.status = ST_OK;
        if (stopped)
        begin
            res.status = ST_HALTED;
        end
        else
        begin
            if (use_reg)
                b = (idx < MEM_DEPTH) ? mem[idx] : '0;
            else
                b = imm;
            case (o)
                OP_ADD: acc = acc + b;
                OP_SUB: acc = acc - b;
                OP_MUL: acc = acc * b;
                OP_DIV, OP_MOD:
                begin
                    if (b == '0)
                    begin
                        res.status = ST_DIV_ZERO;
                    end
                    else
                    begin
                        // magnitudes as unsigned, so the most negative value stays 2^31
                        mag_a = acc[ACC_W-1] ? -acc : acc;
                        mag_b = b[ACC_W-1] ? -b : b;
                        quo = mag_a / mag_b;
                        rem = mag_a % mag_b;
                        if (o == OP_DIV)
                            acc = (acc[ACC_W-1] ^ b[ACC_W-1]) ? -quo : quo;
                        else
                            acc = acc[ACC_W-1] ? -rem : rem;
                    end
                end
                OP_LOAD: acc = b;
                OP_STORE:
                begin
                    if (use_reg && idx < MEM_DEPTH)
                        mem[idx] = acc;
                end
                OP_IN: acc = imm;
                OP_OUT: res.emit = 1'b1;
                OP_CLEAR:
                begin
                    acc = '0;
                    foreach (mem[i]) mem[i] = '0;
                end
                OP_END: stopped = 1'b1;
                default: ;
            endcase
        end
        res.acc = acc;
        res.halted = stopped;
        owed_results.push_back(res);
    endfunction

    function void check_result(input logic [ACC_W-1:0] a, input logic e,
                               input status_t s, input logic h);
        exec_result_t want;
        if (owed_results.size() == 0)
        begin
            $error("result beat with no instruction outstanding");
            mismatches++;
            return;
        end
        want = owed_results.pop_front();
        if (a !== want.acc)
        begin
            $error("accumulator: expected %0d, got %0d", $signed(want.acc), $signed(a));
            mismatches++;
        end
        if (e !== want.emit)
        begin
            $error("emit: expected %0d, got %0d", want.emit, e);
            mismatches++;
        end
        if (s !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, s);
            mismatches++;
        end
        if (h !== want.halted)
        begin
            $error("halted: expected %0d, got %0d", want.halted, h);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int RANDOM_INSTRS = 800;
    localparam int DRAIN_AT      = 400;
    localparam int HOLDOFF_AT    = 150;
    localparam int HOLDOFF_LEN   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      op = '0;
    logic                 operand_is_register = 1'b0;
    logic [IDX_W-1:0]     register_index = '0;
    logic [IMM_W-1:0]     immediate_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ACC_W-1:0]     accumulator;
    logic                 emit;
    logic [STATUS_W-1:0]  status;
    logic                 halted;

    acc_machine_tracker board = new();
    bit tx_eager = 1'b0;
    int quiet_cycles = 0;

    accumulator_machine_executor i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .op                  (op),
        .operand_is_register (operand_is_register),
        .register_index      (register_index),
        .immediate_value     (immediate_value),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .accumulator         (accumulator),
        .emit                (emit),
        .status              (status),
        .halted              (halted)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic issue_instr(input opcode_t o, input logic use_reg,
                               input logic [IDX_W-1:0] idx, input logic [IMM_W-1:0] imm);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        operand_is_register <= use_reg;
        register_index <= idx;
        immediate_value <= imm;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.execute_instr(o, use_reg, idx, imm);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending_count() != 0) @(posedge clk);
    endtask

    // result side: random stalls, eager stretches and one long holdoff
    initial
    begin : result_sink
        int stall;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 50 == 0)
                eager = ($urandom_range(0, 2) == 0);
            if (taken == HOLDOFF_AT)
                stall = HOLDOFF_LEN;
            else
                stall = eager ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_result(accumulator, emit, status, halted);
            taken++;
        end
    end

    initial
    begin : stimulus
        opcode_t          o;
        logic             use_reg;
        logic [IDX_W-1:0] idx;
        logic [IMM_W-1:0] imm;
        int               kind;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wrap on add and sub, out-of-range and immediate stores
        issue_instr(OP_IN, 1'b0, 4'd0, 32'h7fff_ffff);
        issue_instr(OP_ADD, 1'b0, 4'd0, 32'd1);
        issue_instr(OP_SUB, 1'b0, 4'd0, 32'd1);
        issue_instr(OP_STORE, 1'b1, 4'd0, 32'd0);
        issue_instr(OP_STORE, 1'b1, 4'd9, 32'd0);
        issue_instr(OP_STORE, 1'b1, 4'd15, 32'd0);
        issue_instr(OP_STORE, 1'b0, 4'd3, 32'hdead_beef);
        // most negative over minus one
        issue_instr(OP_IN, 1'b0, 4'd0, 32'h8000_0000);
        issue_instr(OP_DIV, 1'b0, 4'd0, 32'hffff_ffff);
        issue_instr(OP_MOD, 1'b0, 4'd0, 32'hffff_ffff);
        // truncation toward zero and remainder sign
        issue_instr(OP_IN, 1'b0, 4'd0, -32'sd7);
        issue_instr(OP_DIV, 1'b0, 4'd0, 32'd2);
        issue_instr(OP_IN, 1'b0, 4'd0, -32'sd7);
        issue_instr(OP_MOD, 1'b0, 4'd0, 32'd2);
        issue_instr(OP_IN, 1'b0, 4'd0, 32'd7);
        issue_instr(OP_MOD, 1'b0, 4'd0, -32'sd2);
        // zero divisors, immediate and out-of-range register
        issue_instr(OP_DIV, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_MOD, 1'b1, 4'd12, 32'd5);
        issue_instr(OP_LOAD, 1'b1, 4'd0, 32'd0);
        issue_instr(OP_MUL, 1'b1, 4'd9, 32'd0);
        issue_instr(OP_OUT, 1'b0, 4'd0, 32'd0);
        issue_instr(opcode_t'(4'd15), 1'b1, 4'd5, 32'hffff_ffff);
        issue_instr(OP_CLEAR, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_LOAD, 1'b1, 4'd9, 32'd0);
        issue_instr(OP_OUT, 1'b0, 4'd0, 32'd0);

        for (int n = 0; n < RANDOM_INSTRS; n++)
        begin
            if (n % 60 == 0)
                tx_eager = ($urandom_range(0, 2) == 0);
            if (n == DRAIN_AT)
                drain_results();
            // end is held back for the tail, since nothing after it executes
            if ($urandom_range(0, 19) == 0)
                o = opcode_t'($urandom_range(11, 15));
            else
                o = opcode_t'($urandom_range(0, 9));
            use_reg = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0)
                idx = IDX_W'($urandom_range(10, 15));
            else
                idx = IDX_W'($urandom_range(0, 9));
            kind = $urandom_range(0, 5);
            case (kind)
                0: imm = $urandom_range(0, 16) - 8;
                1:
                begin
                    case ($urandom_range(0, 4))
                        0: imm = 32'h8000_0000;
                        1: imm = 32'h7fff_ffff;
                        2: imm = 32'hffff_ffff;
                        3: imm = 32'd1;
                        default: imm = 32'd0;
                    endcase
                end
                2: imm = $urandom_range(0, 1000);
                default: imm = $urandom;
            endcase
            issue_instr(o, use_reg, idx, imm);
        end

        // halt, then everything afterwards is ignored
        tx_eager = 1'b0;
        issue_instr(OP_END, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_ADD, 1'b0, 4'd0, 32'd5);
        issue_instr(OP_OUT, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_CLEAR, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_DIV, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_END, 1'b0, 4'd0, 32'd0);
        issue_instr(OP_IN, 1'b0, 4'd0, 32'h1234_5678);
        issue_instr(OP_STORE, 1'b1, 4'd2, 32'd0);
        issue_instr(opcode_t'(4'd12), 1'b0, 4'd0, 32'd0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_count() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ame_pkg.sv
src/ame_alu.sv
src/accumulator_machine_executor.sv
src/ame_checker.sv
tb/testbench.sv
